// File: sv/tsf_pkg.sv
// ----------------------------------------------------------------------------
// tsf_pkg
// types and constants for the thinning sub-pass filter
// ----------------------------------------------------------------------------
`default_nettype none

package tsf_pkg;

    localparam int CNT_W = 11;
    localparam int PIX_W = 8;
    localparam int CFG_IDX_W = 2;

    localparam logic [3:0] MIN_NEIGHBORS = 4'd2;
    localparam logic [3:0] MAX_NEIGHBORS = 4'd6;

    localparam logic [CNT_W-1:0] RESET_WIDTH  = 11'd320;
    localparam logic [CNT_W-1:0] RESET_HEIGHT = 11'd240;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_SUBPASS      = 2'd2
    } t_cfg_idx;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [PIX_W-1:0] pixel_in;
    } t_in_word;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } t_out_word;

    typedef struct packed {
        logic [PIX_W-1:0] upper;
        logic [PIX_W-1:0] lower;
    } t_line_pair;

    // [row][col], row 0 is north, col 0 is west
    typedef logic [2:0][2:0][PIX_W-1:0] t_window;

endpackage

`default_nettype wire

// File: sv/thinning_subpass_filter.sv
// ----------------------------------------------------------------------------
// thinning_subpass_filter
// one thinning sub-iteration over a raster-order binary image, 3x3 window
// ----------------------------------------------------------------------------
// Takes one word per clock unless stalled. The result for the pixel one row
// and one column behind the newest word is registered as that word leaves
// stage 1. Each frame is followed by image_width+1 flush words. Both line
// buffers sit in one memory of MAX_WIDTH entries, read once and written once
// per word; that single read-modify-write per word sets the rate of one word
// per clock. A stalled output holds one finished word and one more word that
// gives a result waits behind it; words that give no result keep flowing.
// ----------------------------------------------------------------------------
`default_nettype none

module thinning_subpass_filter #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire tsf_pkg::t_in_word                 i_in_word,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output tsf_pkg::t_out_word                     o_out_word,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [tsf_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [tsf_pkg::CNT_W-1:0]         i_cfg_data
);

    localparam int CW = tsf_pkg::CNT_W;
    localparam int PW = tsf_pkg::PIX_W;
    localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    function automatic logic [PW-1:0] thin_center(input tsf_pkg::t_window w,
                                                  input logic sp);
        logic [7:0] ring;
        logic [3:0] b;
        logic [3:0] a;
        logic       n, e, s, wst, del;
        ring = {w[0][0] != '0, w[1][0] != '0, w[2][0] != '0, w[2][1] != '0,
                w[2][2] != '0, w[1][2] != '0, w[0][2] != '0, w[0][1] != '0};
        n   = ring[0];
        e   = ring[2];
        s   = ring[4];
        wst = ring[6];
        b = '0;
        a = '0;
        for (int k = 0; k < 8; k++) begin
            b = b + 4'(ring[k]);
            a = a + 4'(ring[k] & ~ring[(k + 7) % 8]);
        end
        if (sp == 1'b0) begin
            del = !(e && s && (n || wst));
        end else begin
            del = !(n && wst && (e || s));
        end
        if (w[1][1] == '0 || b < tsf_pkg::MIN_NEIGHBORS || b > tsf_pkg::MAX_NEIGHBORS ||
            a != 4'd1 || !del) begin
            thin_center = w[1][1];
        end else begin
            thin_center = '0;
        end
    endfunction

    // configuration
    logic [CW-1:0] r_cfg_width;
    logic [CW-1:0] r_cfg_height;
    logic          r_cfg_subpass;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width   <= tsf_pkg::RESET_WIDTH;
            r_cfg_height  <= tsf_pkg::RESET_HEIGHT;
            r_cfg_subpass <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                tsf_pkg::CFG_IMAGE_WIDTH:  r_cfg_width   <= i_cfg_data;
                tsf_pkg::CFG_IMAGE_HEIGHT: r_cfg_height  <= i_cfg_data;
                tsf_pkg::CFG_SUBPASS:      r_cfg_subpass <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective frame size
    logic [CW-1:0] wd, ht;

    always_comb begin
        if (r_cfg_width == '0) begin
            wd = CW'(1);
        end else if (32'(r_cfg_width) > MAX_WIDTH) begin
            wd = CW'(MAX_WIDTH);
        end else begin
            wd = r_cfg_width;
        end
        if (r_cfg_height == '0) begin
            ht = CW'(1);
        end else if (32'(r_cfg_height) > MAX_HEIGHT) begin
            ht = CW'(MAX_HEIGHT);
        end else begin
            ht = r_cfg_height;
        end
    end

    // input side: raster position and line buffer read
    logic [CW-1:0]    r_in_col, r_in_row;
    logic [CW-1:0]    s0_col, n_in_col, n_in_row;
    logic [PW-1:0]    s0_newv;
    logic             s0_top_ok, s0_mid_ok, s0_emit, s0_last;
    logic [CW+AW-1:0] s0_addr_ext;
    logic [AW-1:0]    s0_addr;
    logic             in_accept;

    always_comb begin
        s0_col = (r_in_col >= wd) ? '0 : r_in_col;
        s0_newv = (i_in_word.operation == tsf_pkg::OP_PIXEL && r_in_row < ht)
                  ? i_in_word.pixel_in : '0;
        s0_top_ok = (r_in_row >= CW'(2)) && ((r_in_row - CW'(2)) < ht);
        s0_mid_ok = (r_in_row >= CW'(1)) && ((r_in_row - CW'(1)) < ht);
        s0_emit = (r_in_row >= CW'(2)) || (r_in_row == CW'(1) && s0_col != '0);
        s0_last = {1'b0, r_in_row} >= ({1'b0, ht} + (CW+1)'(1));
        s0_addr_ext = {{AW{1'b0}}, s0_col};
        s0_addr = s0_addr_ext[AW-1:0];
        if (s0_emit && s0_last) begin
            n_in_col = '0;
            n_in_row = '0;
        end else if (({1'b0, s0_col} + (CW+1)'(1)) >= {1'b0, wd}) begin
            n_in_col = '0;
            n_in_row = r_in_row + CW'(1);
        end else begin
            n_in_col = s0_col + CW'(1);
            n_in_row = r_in_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col <= '0;
            r_in_row <= '0;
        end else if (in_accept) begin
            r_in_col <= n_in_col;
            r_in_row <= n_in_row;
        end
    end

    // stage 1: line data, window update, thinning
    logic                r_s1_valid;
    logic                r_s1_col_zero, r_s1_top_ok, r_s1_mid_ok, r_s1_emit, r_s1_last;
    logic [PW-1:0]       r_s1_newv;
    logic [AW-1:0]       r_s1_addr;
    logic                r_s1_byp;
    tsf_pkg::t_line_pair r_s1_byp_data;
    tsf_pkg::t_line_pair r_rd_data;
    tsf_pkg::t_line_pair s1_line, n_line_wr;
    tsf_pkg::t_line_pair line_mem [MAX_WIDTH];
    tsf_pkg::t_window    r_window, n_window, s1_win;
    logic [PW-1:0]       s1_top, s1_mid;
    logic                out_free, s1_adv;

    logic                r_out_valid;
    tsf_pkg::t_out_word  r_out_word;

    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_adv     = r_s1_valid && (!r_s1_emit || out_free);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;

    always_comb begin
        s1_line = r_s1_byp ? r_s1_byp_data : r_rd_data;
        s1_top  = r_s1_top_ok ? s1_line.upper : '0;
        s1_mid  = r_s1_mid_ok ? s1_line.lower : '0;
        n_line_wr.upper = s1_line.lower;
        n_line_wr.lower = r_s1_newv;
        // column 0 closes the previous row: its east side is outside the frame
        for (int i = 0; i < 3; i++) begin
            s1_win[i][0]   = r_window[i][1];
            s1_win[i][1]   = r_window[i][2];
            n_window[i][0] = r_s1_col_zero ? '0 : r_window[i][1];
            n_window[i][1] = r_s1_col_zero ? '0 : r_window[i][2];
        end
        s1_win[0][2]   = r_s1_col_zero ? '0 : s1_top;
        s1_win[1][2]   = r_s1_col_zero ? '0 : s1_mid;
        s1_win[2][2]   = r_s1_col_zero ? '0 : r_s1_newv;
        n_window[0][2] = s1_top;
        n_window[1][2] = s1_mid;
        n_window[2][2] = r_s1_newv;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            line_mem[r_s1_addr] <= n_line_wr;
        end
        if (in_accept) begin
            r_rd_data <= line_mem[s0_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_col_zero <= (s0_col == '0);
            r_s1_top_ok   <= s0_top_ok;
            r_s1_mid_ok   <= s0_mid_ok;
            r_s1_emit     <= s0_emit;
            r_s1_last     <= s0_last;
            r_s1_newv     <= s0_newv;
            r_s1_addr     <= s0_addr;
            r_s1_byp      <= s1_adv && (r_s1_addr == s0_addr);
            r_s1_byp_data <= n_line_wr;
        end
        if (s1_adv) begin
            r_window <= n_window;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_adv && r_s1_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_adv && r_s1_emit) begin
            r_out_word.pixel_out <= thin_center(s1_win, r_cfg_subpass);
            r_out_word.frame_end <= r_s1_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // checks
    a_stall_only_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_s1_valid && r_s1_emit && r_out_valid && !i_out_ready))
        else $error("input stalled without a blocked output");

    a_frame_end_resets_position: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && s0_emit && s0_last) |=> (r_in_col == '0 && r_in_row == '0))
        else $error("raster position not cleared after frame end");

    a_output_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_s1_valid && r_s1_emit))
        else $error("output word without an emitting stage 1 word");

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the thinning sub-pass filter
// ----------------------------------------------------------------------------
// Streams raster frames through the filter and checks every output word
// against a predictor that keeps its own line buffers and 3x3 window. The
// frames cover both sub-passes, zero sizes and an oversize width. They
// include flush words inside the image, pixels in the flush tail and size
// changes in mid-frame. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_DEPTH = 1024;
    localparam int MAX_ROWS = 1024;
    localparam int DRAIN_CYCLES = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_WORDS = 700;
    localparam logic [tsf_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum int {PAT_NOISE, PAT_BLOB, PAT_SOLID} t_pattern;

    class thin_checker;
        logic [tsf_pkg::CNT_W-1:0] width_reg;
        logic [tsf_pkg::CNT_W-1:0] height_reg;
        logic subpass_reg;
        logic [tsf_pkg::PIX_W-1:0] upper_mem [LINE_DEPTH];
        logic [tsf_pkg::PIX_W-1:0] lower_mem [LINE_DEPTH];
        logic [tsf_pkg::PIX_W-1:0] win [3][3];
        int unsigned in_col;
        int unsigned in_row;
        tsf_pkg::t_out_word expected_pixels [$];
        int errors;
        bit frame_done;

        function new();
            width_reg = tsf_pkg::RESET_WIDTH;
            height_reg = tsf_pkg::RESET_HEIGHT;
            subpass_reg = 1'b0;
            for (int i = 0; i < LINE_DEPTH; i++) begin
                upper_mem[i] = '0;
                lower_mem[i] = '0;
            end
            clear_window();
            in_col = 0;
            in_row = 0;
            errors = 0;
            frame_done = 1'b0;
        endfunction

        function void clear_window();
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    win[i][j] = '0;
                end
            end
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            return (width_reg > LINE_DEPTH) ? LINE_DEPTH : int'(width_reg);
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            return (height_reg > MAX_ROWS) ? MAX_ROWS : int'(height_reg);
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        function void write_reg(logic [tsf_pkg::CFG_IDX_W-1:0] idx,
                                logic [tsf_pkg::CNT_W-1:0] data);
            case (idx)
                tsf_pkg::CFG_IMAGE_WIDTH: width_reg = data;
                tsf_pkg::CFG_IMAGE_HEIGHT: height_reg = data;
                tsf_pkg::CFG_SUBPASS: subpass_reg = data[0];
                default: ;
            endcase
        endfunction

        function logic [tsf_pkg::PIX_W-1:0] thinned_center();
            bit nb_n, nb_ne, nb_e, nb_se, nb_s, nb_sw, nb_w, nb_nw;
            bit ring [8];
            int nbrs;
            int rises;
            int k;
            bit del;
            if (win[1][1] == '0) return '0;
            nb_n = win[0][1] != '0;
            nb_ne = win[0][2] != '0;
            nb_e = win[1][2] != '0;
            nb_se = win[2][2] != '0;
            nb_s = win[2][1] != '0;
            nb_sw = win[2][0] != '0;
            nb_w = win[1][0] != '0;
            nb_nw = win[0][0] != '0;
            ring = '{nb_n, nb_ne, nb_e, nb_se, nb_s, nb_sw, nb_w, nb_nw};
            nbrs = 0;
            rises = 0;
            for (k = 0; k < 8; k++) begin
                if (ring[k]) begin
                    nbrs++;
                    if (!ring[(k + 7) % 8]) rises++;
                end
            end
            if (nbrs < tsf_pkg::MIN_NEIGHBORS || nbrs > tsf_pkg::MAX_NEIGHBORS || rises != 1)
                return win[1][1];
            if (subpass_reg == 1'b0) del = !(nb_e && nb_s && (nb_n || nb_w));
            else del = !(nb_n && nb_w && (nb_e || nb_s));
            return del ? '0 : win[1][1];
        endfunction

        // advance one raster position, queue the output word it causes
        function void take_word(tsf_pkg::t_in_word word);
            int unsigned wd, ht, r, c;
            logic [tsf_pkg::PIX_W-1:0] top, mid, bot;
            bit emit, last;
            tsf_pkg::t_out_word res;
            wd = eff_width();
            ht = eff_height();
            r = in_row;
            c = in_col;
            if (c >= wd) c = 0;
            bot = (word.operation == tsf_pkg::OP_PIXEL && r < ht) ? word.pixel_in : '0;
            top = '0;
            mid = '0;
            if (r >= 2 && r - 2 < ht) top = upper_mem[c];
            if (r >= 1 && r - 1 < ht) mid = lower_mem[c];
            upper_mem[c] = lower_mem[c];
            lower_mem[c] = bot;
            emit = (r >= 2) || (r == 1 && c >= 1);
            last = (r >= ht + 1);
            for (int i = 0; i < 3; i++) begin
                win[i][0] = win[i][1];
                win[i][1] = win[i][2];
                win[i][2] = '0;
            end
            if (c != 0) begin
                win[0][2] = top;
                win[1][2] = mid;
                win[2][2] = bot;
            end
            if (emit) begin
                res.pixel_out = thinned_center();
                res.frame_end = last;
                expected_pixels.push_back(res);
            end
            // new row: west border is outside the frame
            if (c == 0) begin
                for (int i = 0; i < 3; i++) begin
                    win[i][0] = '0;
                    win[i][1] = '0;
                end
                win[0][2] = top;
                win[1][2] = mid;
                win[2][2] = bot;
            end
            if (emit && last) begin
                clear_window();
                in_col = 0;
                in_row = 0;
                frame_done = 1'b1;
            end else if (c + 1 >= wd) begin
                in_col = 0;
                in_row = (r + 1) & 32'h7FF;
            end else begin
                in_col = c + 1;
                in_row = r;
            end
        endfunction

        function void match_result(tsf_pkg::t_out_word got);
            tsf_pkg::t_out_word want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected word: pixel_out %0d frame_end %0d",
                       got.pixel_out, got.frame_end);
                errors++;
                return;
            end
            want = expected_pixels.pop_front();
            if (got.pixel_out !== want.pixel_out) begin
                $error("pixel_out: expected %0d, actual %0d", want.pixel_out, got.pixel_out);
                errors++;
            end
            if (got.frame_end !== want.frame_end) begin
                $error("frame_end: expected %0d, actual %0d", want.frame_end, got.frame_end);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    tsf_pkg::t_in_word i_in_word = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    tsf_pkg::t_out_word o_out_word;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [tsf_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [tsf_pkg::CNT_W-1:0] i_cfg_data = '0;

    thin_checker board;
    int in_gap_max = 10;
    int out_gap_max = 10;
    int words_sent = 0;
    int idle_cycles = 0;
    t_pattern pattern = PAT_NOISE;
    int density = 50;
    int noise_pct = 0;
    int blob_r0, blob_r1, blob_c0, blob_c1;

    thinning_subpass_filter #(
        .MAX_WIDTH(LINE_DEPTH),
        .MAX_HEIGHT(MAX_ROWS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_in_word(i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word(o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [tsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tsf_pkg::CNT_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        board.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic send_word(input logic op, input logic [tsf_pkg::PIX_W-1:0] pix);
        int gap;
        tsf_pkg::t_in_word word;
        gap = $urandom_range(0, in_gap_max);
        word.operation = op;
        word.pixel_in = pix;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= word;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        board.take_word(word);
        words_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [tsf_pkg::PIX_W-1:0] pattern_pixel(int k);
        int wd, row, col;
        bit fg;
        wd = board.eff_width();
        row = k / wd;
        col = k % wd;
        if (pattern == PAT_NOISE) fg = $urandom_range(0, 99) < density;
        else fg = row >= blob_r0 && row <= blob_r1 && col >= blob_c0 && col <= blob_c1
                  && $urandom_range(0, 99) >= density;
        if (!fg) return '0;
        return ($urandom_range(0, 3) == 0) ? 8'hFF : tsf_pkg::PIX_W'($urandom_range(1, 255));
    endfunction

    task automatic stream(inout int k, input int limit);
        int sent, area;
        bit noisy;
        sent = 0;
        while (!board.frame_done && sent < limit) begin
            area = board.eff_width() * board.eff_height();
            noisy = $urandom_range(0, 99) < noise_pct;
            if ((k < area) != noisy)
                send_word(tsf_pkg::OP_PIXEL, (k < area) ? pattern_pixel(k)
                          : tsf_pkg::PIX_W'($urandom_range(0, 255)));
            else
                send_word(tsf_pkg::OP_FLUSH, tsf_pkg::PIX_W'($urandom_range(0, 255)));
            k++;
            sent++;
        end
    endtask

    task automatic run_frame(input logic [tsf_pkg::CNT_W-1:0] w,
                             input logic [tsf_pkg::CNT_W-1:0] h,
                             input logic sp, input t_pattern pat, input int fill,
                             input int noise, input bit split);
        int k, cut, ew, eh;
        logic [tsf_pkg::CNT_W-1:0] sub_data;
        write_reg(tsf_pkg::CFG_IMAGE_WIDTH, w);
        write_reg(tsf_pkg::CFG_IMAGE_HEIGHT, h);
        sub_data = tsf_pkg::CNT_W'($urandom_range(0, 2047));
        sub_data[0] = sp;
        write_reg(tsf_pkg::CFG_SUBPASS, sub_data);
        ew = board.eff_width();
        eh = board.eff_height();
        pattern = pat;
        density = fill;
        noise_pct = noise;
        blob_r0 = 0;
        blob_r1 = eh - 1;
        blob_c0 = 0;
        blob_c1 = ew - 1;
        if (pat == PAT_BLOB) begin
            blob_r0 = $urandom_range(0, eh - 1);
            blob_r1 = $urandom_range(blob_r0, eh - 1);
            blob_c0 = $urandom_range(0, ew - 1);
            blob_c1 = $urandom_range(blob_c0, ew - 1);
        end
        board.frame_done = 1'b0;
        k = 0;
        if (split) begin
            cut = $urandom_range(1, ew * eh);
            stream(k, cut);
            settle();
            write_reg(tsf_pkg::CFG_IMAGE_WIDTH, tsf_pkg::CNT_W'($urandom_range(1, 16)));
            write_reg(tsf_pkg::CFG_IMAGE_HEIGHT, tsf_pkg::CNT_W'($urandom_range(1, 12)));
        end
        stream(k, 32'h7FFF_FFFF);
        settle();
    endtask

    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        gap = $urandom_range(0, out_gap_max);
        forever begin
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid === 1'b1 && i_out_ready));
            board.match_result(o_out_word);
            gap = $urandom_range(0, out_gap_max);
        end
    end

    initial begin
        int start_words;
        logic [tsf_pkg::CNT_W-1:0] w, h;
        int pick;
        int k;
        board = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero sizes act as a single pixel
        run_frame(11'd0, 11'd0, 1'b0, PAT_SOLID, 0, 0, 1'b0);
        run_frame(11'd4, 11'd4, 1'b0, PAT_SOLID, 0, 0, 1'b0);
        run_frame(11'd4, 11'd4, 1'b1, PAT_SOLID, 0, 0, 1'b0);
        // flush words inside the image, pixels in the flush tail
        run_frame(11'd5, 11'd3, 1'b1, PAT_NOISE, 50, 30, 1'b0);
        write_reg(CFG_UNUSED, tsf_pkg::CNT_W'($urandom_range(0, 2047)));
        // oversize width wraps rows at the line depth, then the frame ends narrow
        write_reg(tsf_pkg::CFG_IMAGE_WIDTH, 11'd2047);
        write_reg(tsf_pkg::CFG_IMAGE_HEIGHT, 11'd2);
        write_reg(tsf_pkg::CFG_SUBPASS, 11'd0);
        pattern = PAT_NOISE;
        density = 50;
        noise_pct = 0;
        board.frame_done = 1'b0;
        k = 0;
        stream(k, LINE_DEPTH + 2);
        settle();
        write_reg(tsf_pkg::CFG_IMAGE_WIDTH, 11'd4);
        stream(k, 32'h7FFF_FFFF);
        settle();
        run_frame(11'd1, 11'd3, 1'b0, PAT_NOISE, 70, 0, 1'b0);
        run_frame(11'd6, 11'd5, 1'b0, PAT_BLOB, 0, 0, 1'b1);

        start_words = words_sent;
        while (words_sent - start_words < RANDOM_WORDS) begin
            w = tsf_pkg::CNT_W'($urandom_range(1, 12));
            h = tsf_pkg::CNT_W'($urandom_range(1, 10));
            if ($urandom_range(0, 19) == 0) w = '0;
            else if ($urandom_range(0, 19) == 0) w = tsf_pkg::CNT_W'($urandom_range(13, 64));
            if ($urandom_range(0, 19) == 0) h = '0;
            pick = $urandom_range(0, 9);
            run_frame(w, h, 1'($urandom_range(0, 1)),
                      (pick < 4) ? PAT_NOISE : (pick < 9) ? PAT_BLOB : PAT_SOLID,
                      (pick < 4) ? $urandom_range(20, 80) : $urandom_range(0, 15),
                      ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(1, 10),
                      $urandom_range(0, 9) == 0);
        end

        i_in_valid <= 1'b0;
        repeat (2 * DRAIN_CYCLES) @(posedge i_clk);
        if (board.pending() != 0)
            $error("%0d expected words never arrived", board.pending());
        if (board.errors == 0 && board.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: sim.f
sv/tsf_pkg.sv
sv/thinning_subpass_filter.sv
tb/testbench.sv
